>>> hw/rtl/cylinder_vertex_generator_core_assert.svh
// Assertion macros shared by the cylinder vertex generator RTL.
// Each macro expands to one labeled concurrent assertion, clocked on the rising edge,
// disabled while the active-low reset is asserted.
`ifndef CYLINDER_VERTEX_GENERATOR_CORE_ASSERT_SVH
`define CYLINDER_VERTEX_GENERATOR_CORE_ASSERT_SVH

// Expression holds on every cycle out of reset.
`define CVG_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CVG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CVG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/cvg_pkg.sv
// Shared types and constants for the cylinder vertex generator.
// No dependencies; used by every module of the block.
`default_nettype none

package cvg_pkg;

    // Field widths
    localparam int unsigned ANGLE_W   = 16;
    localparam int unsigned INDEX_W   = 10;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned RADIUS_W  = 23;
    localparam int unsigned POS_W     = 24;
    localparam int unsigned NORM_W    = 16;
    localparam int unsigned SLOT_W    = 3;
    localparam int unsigned SINE_W    = 15;
    // Cell heights reach 1024 * (2^23 - 1), which fits in 33 bits
    localparam int unsigned HEIGHT_W  = 33;

    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 112;
    localparam int unsigned CFG_DATA_W  = 24;
    localparam int unsigned CFG_IDX_W   = 3;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;
    localparam logic [SLOT_W-1:0]  LAST_SLOT    = 3'd5;

    // Depth of the vertex command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS      = 3'd0,
        CFG_CYL_HEIGHT  = 3'd1,
        CFG_BASE_X      = 3'd2,
        CFG_BASE_Y      = 3'd3,
        CFG_BASE_Z      = 3'd4,
        CFG_ANGLE_STEP  = 3'd5,
        CFG_HEIGHT_STEP = 3'd6
    } t_cfg_reg;

    // Configuration reset values
    localparam logic [RADIUS_W-1:0] RADIUS_RESET      = 23'd4096;
    localparam logic [RADIUS_W-1:0] CYL_HEIGHT_RESET  = 23'd4096;
    localparam logic [ANGLE_W-1:0]  ANGLE_STEP_RESET  = 16'd4096;
    localparam logic [RADIUS_W-1:0] HEIGHT_STEP_RESET = 23'd256;

    // One vertex to be generated: angle, unsigned height above base, slot, last flag
    typedef struct packed {
        logic [ANGLE_W-1:0]  angle;
        logic [HEIGHT_W-1:0] height;
        logic [SLOT_W-1:0]   slot;
        logic                last;
    } t_vtx_cmd;

endpackage

`default_nettype wire

>>> hw/rtl/cylinder_vertex_generator_core.sv
// Path: an accepted item passes the front input and expansion registers, the command
// queue and the back-end pipeline. Throughput: one vertex per cycle while m_axis_tready
// is high; the front sequencer issues six vertex commands per cell item, one per sample.
// Reset (synchronous, active low) clears all handshake state and loads the register
// defaults; the sine ROM is constant, so there is no clearing pass.
// Depends on cvg_pkg, cvg_front, cvg_queue, cvg_back.
`default_nettype none

module cylinder_vertex_generator_core #(
    parameter int unsigned MAX_CELLS    = 1024,
    parameter int unsigned SINE_ENTRIES = 1024
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Configuration write channel
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [cvg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [cvg_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // Input items
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata: theta_index[9:0], height_index[19:10], turn_fraction[35:20],
    //        z_fraction[51:36], zero pad[55:52]
    input  wire logic [cvg_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // tuser: action[0]
    input  wire logic                                 s_axis_tuser,
    // Vertex results
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // tdata: pos_x[23:0], pos_y[47:24], pos_z[71:48], normal_x[87:72],
    //        normal_y[103:88], vertex_slot[106:104], zero pad[111:107]
    output logic [cvg_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
    output logic                                      m_axis_tlast
);

    // Configuration registers
    logic [cvg_pkg::RADIUS_W-1:0]        r_radius;
    logic [cvg_pkg::RADIUS_W-1:0]        r_cyl_height;
    logic signed [cvg_pkg::POS_W-1:0]    r_base_x;
    logic signed [cvg_pkg::POS_W-1:0]    r_base_y;
    logic signed [cvg_pkg::POS_W-1:0]    r_base_z;
    logic [cvg_pkg::ANGLE_W-1:0]         r_angle_step;
    logic [cvg_pkg::RADIUS_W-1:0]        r_height_step;

    logic                                cfg_write;
    logic                                f_cmd_valid;
    logic                                f_cmd_ready;
    cvg_pkg::t_vtx_cmd                   f_cmd;
    logic                                q_cmd_valid;
    logic                                q_cmd_ready;
    cvg_pkg::t_vtx_cmd                   q_cmd;
    logic signed [cvg_pkg::POS_W-1:0]    pos_x;
    logic signed [cvg_pkg::POS_W-1:0]    pos_y;
    logic signed [cvg_pkg::POS_W-1:0]    pos_z;
    logic signed [cvg_pkg::NORM_W-1:0]   normal_x;
    logic signed [cvg_pkg::NORM_W-1:0]   normal_y;
    logic [cvg_pkg::SLOT_W-1:0]          vertex_slot;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius      <= cvg_pkg::RADIUS_RESET;
            r_cyl_height  <= cvg_pkg::CYL_HEIGHT_RESET;
            r_base_x      <= '0;
            r_base_y      <= '0;
            r_base_z      <= '0;
            r_angle_step  <= cvg_pkg::ANGLE_STEP_RESET;
            r_height_step <= cvg_pkg::HEIGHT_STEP_RESET;
        end else if (cfg_write) begin
            case (i_cfg_index)
                cvg_pkg::CFG_RADIUS: begin
                    r_radius <= i_cfg_data[cvg_pkg::RADIUS_W-1:0];
                end
                cvg_pkg::CFG_CYL_HEIGHT: begin
                    r_cyl_height <= i_cfg_data[cvg_pkg::RADIUS_W-1:0];
                end
                cvg_pkg::CFG_BASE_X: begin
                    r_base_x <= i_cfg_data;
                end
                cvg_pkg::CFG_BASE_Y: begin
                    r_base_y <= i_cfg_data;
                end
                cvg_pkg::CFG_BASE_Z: begin
                    r_base_z <= i_cfg_data;
                end
                cvg_pkg::CFG_ANGLE_STEP: begin
                    r_angle_step <= i_cfg_data[cvg_pkg::ANGLE_W-1:0];
                end
                cvg_pkg::CFG_HEIGHT_STEP: begin
                    r_height_step <= i_cfg_data[cvg_pkg::RADIUS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    cvg_front #(
        .MAX_CELLS (MAX_CELLS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_axis_tvalid),
        .o_in_ready      (s_axis_tready),
        .i_action        (s_axis_tuser),
        .i_theta_index   (s_axis_tdata[9:0]),
        .i_height_index  (s_axis_tdata[19:10]),
        .i_turn_fraction (s_axis_tdata[35:20]),
        .i_z_fraction    (s_axis_tdata[51:36]),
        .i_cyl_height    (r_cyl_height),
        .i_angle_step    (r_angle_step),
        .i_height_step   (r_height_step),
        .o_cmd_valid     (f_cmd_valid),
        .i_cmd_ready     (f_cmd_ready),
        .o_cmd           (f_cmd)
    );

    cvg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_cmd_valid),
        .o_push_ready (f_cmd_ready),
        .i_push_data  (f_cmd),
        .o_pop_valid  (q_cmd_valid),
        .i_pop_ready  (q_cmd_ready),
        .o_pop_data   (q_cmd)
    );

    cvg_back #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_cmd_valid),
        .o_cmd_ready   (q_cmd_ready),
        .i_cmd         (q_cmd),
        .i_radius      (r_radius),
        .i_base_x      (r_base_x),
        .i_base_y      (r_base_y),
        .i_base_z      (r_base_z),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_pos_x       (pos_x),
        .o_pos_y       (pos_y),
        .o_pos_z       (pos_z),
        .o_normal_x    (normal_x),
        .o_normal_y    (normal_y),
        .o_vertex_slot (vertex_slot),
        .o_last        (m_axis_tlast)
    );

    // Result packing, first field in the low bits
    assign m_axis_tdata = {5'b0, vertex_slot, normal_y, normal_x, pos_z, pos_y, pos_x};

endmodule

`default_nettype wire

>>> hw/rtl/cvg_front.sv
// Front end: accepts input items, forms cell or sample angles and heights, and expands
// each item into vertex commands. Depends on cvg_pkg and the assertion header.
`default_nettype none
`include "cylinder_vertex_generator_core_assert.svh"

module cvg_front #(
    parameter int unsigned MAX_CELLS = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_action,
    input  wire logic [cvg_pkg::INDEX_W-1:0]     i_theta_index,
    input  wire logic [cvg_pkg::INDEX_W-1:0]     i_height_index,
    input  wire logic [cvg_pkg::FRAC_W-1:0]      i_turn_fraction,
    input  wire logic [cvg_pkg::FRAC_W-1:0]      i_z_fraction,
    input  wire logic [cvg_pkg::RADIUS_W-1:0]    i_cyl_height,
    input  wire logic [cvg_pkg::ANGLE_W-1:0]     i_angle_step,
    input  wire logic [cvg_pkg::RADIUS_W-1:0]    i_height_step,
    output logic                                 o_cmd_valid,
    input  wire logic                            i_cmd_ready,
    output cvg_pkg::t_vtx_cmd                    o_cmd
);

    localparam int unsigned IDX_W    = cvg_pkg::INDEX_W;
    localparam int unsigned IDX_FULL = (1 << IDX_W) - 1;
    localparam int unsigned IDX_MAX  = (MAX_CELLS - 1 > IDX_FULL) ? IDX_FULL : MAX_CELLS - 1;
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(IDX_MAX);
    localparam int unsigned TPROD_W  = IDX_W + cvg_pkg::ANGLE_W;
    localparam int unsigned ZPROD_W  = cvg_pkg::FRAC_W + cvg_pkg::RADIUS_W;
    localparam int unsigned HW       = cvg_pkg::HEIGHT_W;

    // Stage A: input register
    logic                          r_a_valid;
    logic                          r_a_action;
    logic [IDX_W-1:0]              r_a_theta;
    logic [IDX_W-1:0]              r_a_height;
    logic [cvg_pkg::FRAC_W-1:0]    r_a_turn;
    logic [cvg_pkg::FRAC_W-1:0]    r_a_zf;

    // Stage B: base angle and height, expansion counter
    logic                          r_b_valid;
    logic                          r_b_action;
    logic [cvg_pkg::ANGLE_W-1:0]   r_b_angle;
    logic [HW-1:0]                 r_b_h0;
    logic [cvg_pkg::SLOT_W-1:0]    r_b_slot;
    logic [cvg_pkg::SLOT_W-1:0]    n_b_slot;

    logic                          in_accept;
    logic                          a_adv;
    logic                          push;
    logic                          b_done;
    logic [IDX_W-1:0]              theta_sat;
    logic [IDX_W-1:0]              height_sat;
    logic [TPROD_W-1:0]            t_prod;
    logic [HW-1:0]                 h_prod;
    logic [ZPROD_W-1:0]            z_prod;
    logic [cvg_pkg::ANGLE_W-1:0]   t1;
    logic [HW-1:0]                 h1;
    logic                          use_t1;
    logic                          use_h1;

    // Handshakes
    assign a_adv      = r_a_valid && (!r_b_valid || b_done);
    assign o_in_ready = !r_a_valid || a_adv;
    assign in_accept  = i_in_valid && o_in_ready;
    assign push       = r_b_valid && i_cmd_ready;
    assign b_done     = push && o_cmd.last;

    // Index clamp and products for the base angle and heights
    always_comb begin
        theta_sat  = (r_a_theta > IDX_LIMIT) ? IDX_LIMIT : r_a_theta;
        height_sat = (r_a_height > IDX_LIMIT) ? IDX_LIMIT : r_a_height;
        t_prod     = TPROD_W'(theta_sat) * TPROD_W'(i_angle_step);
        h_prod     = HW'(height_sat) * HW'(i_height_step);
        z_prod     = ZPROD_W'(r_a_zf) * ZPROD_W'(i_cyl_height) + ZPROD_W'(32768);
    end

    // Corner selection, order 00,10,01,01,10,11
    always_comb begin
        use_t1 = r_b_slot inside {3'd1, 3'd4, 3'd5};
        use_h1 = r_b_slot inside {3'd2, 3'd3, 3'd5};
        t1     = r_b_angle + i_angle_step;
        h1     = r_b_h0 + HW'(i_height_step);
        o_cmd_valid  = r_b_valid;
        o_cmd.angle  = use_t1 ? t1 : r_b_angle;
        o_cmd.height = use_h1 ? h1 : r_b_h0;
        o_cmd.slot   = r_b_slot;
        o_cmd.last   = r_b_action || (r_b_slot == cvg_pkg::LAST_SLOT);
    end

    // Next slot
    always_comb begin
        n_b_slot = r_b_slot;
        if (a_adv) begin
            n_b_slot = '0;
        end else if (push) begin
            n_b_slot = o_cmd.last ? '0 : r_b_slot + 3'd1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_b_slot  <= '0;
        end else begin
            if (in_accept) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_b_valid <= 1'b1;
            end else if (b_done) begin
                r_b_valid <= 1'b0;
            end
            r_b_slot <= n_b_slot;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_action <= i_action;
            r_a_theta  <= i_theta_index;
            r_a_height <= i_height_index;
            r_a_turn   <= i_turn_fraction;
            r_a_zf     <= i_z_fraction;
        end
        if (a_adv) begin
            r_b_action <= r_a_action;
            r_b_angle  <= r_a_action ? r_a_turn : t_prod[cvg_pkg::ANGLE_W-1:0];
            r_b_h0     <= r_a_action ? HW'(z_prod[ZPROD_W-1:16]) : h_prod;
        end
    end

    // Assertions
    `CVG_ASSERT_ALWAYS(a_slot_range, i_clk, i_rst_n, !r_b_valid || (r_b_slot <= cvg_pkg::LAST_SLOT), "slot beyond last")
    `CVG_ASSERT_NEXT(a_reload, i_clk, i_rst_n, b_done && r_a_valid, r_b_valid && (r_b_slot == 3'd0), "waiting item not loaded after run")

endmodule

`default_nettype wire

>>> hw/rtl/cvg_queue.sv
// Short FIFO of vertex commands between the front and back ends.
// Depends on cvg_pkg and the assertion header.
`default_nettype none
`include "cylinder_vertex_generator_core_assert.svh"

module cvg_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push_valid,
    output logic                    o_push_ready,
    input  cvg_pkg::t_vtx_cmd       i_push_data,
    output logic                    o_pop_valid,
    input  wire logic               i_pop_ready,
    output cvg_pkg::t_vtx_cmd       o_pop_data
);

    localparam int unsigned DEPTH = cvg_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    cvg_pkg::t_vtx_cmd r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Assertions
    `CVG_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "queue count overflow")
    `CVG_ASSERT_NEXT(a_count_inc, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + CNT_W'(1), "queue count did not grow")

endmodule

`default_nettype wire

>>> hw/rtl/cvg_sine_rom.sv
// Quarter-wave sine ROM, Q1.14 magnitudes, two registered read ports.
// Contents are built at elaboration from a Q30 Taylor series; depends on cvg_pkg.
`default_nettype none

module cvg_sine_rom #(
    parameter int unsigned SINE_ENTRIES = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_en,
    input  wire logic [$clog2(SINE_ENTRIES+1)-1:0]      i_addr_a,
    input  wire logic [$clog2(SINE_ENTRIES+1)-1:0]      i_addr_b,
    output logic [cvg_pkg::SINE_W-1:0]                  o_data_a,
    output logic [cvg_pkg::SINE_W-1:0]                  o_data_b
);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [cvg_pkg::SINE_W-1:0] t_rom [0:SINE_ENTRIES];

    // entry k = round(16384 * sin(pi*k / (2*SINE_ENTRIES))), Taylor series to x^15
    function automatic t_rom f_build_rom();
        t_rom               tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        for (int unsigned k = 0; k <= SINE_ENTRIES; k++) begin
            x    = (64'(k) * HALF_PI_Q30) / SINE_ENTRIES;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            term = ((term * x2) / 64'd6) >> 30;
            sum  = sum - $signed(term);
            term = ((term * x2) / 64'd20) >> 30;
            sum  = sum + $signed(term);
            term = ((term * x2) / 64'd42) >> 30;
            sum  = sum - $signed(term);
            term = ((term * x2) / 64'd72) >> 30;
            sum  = sum + $signed(term);
            term = ((term * x2) / 64'd110) >> 30;
            sum  = sum - $signed(term);
            term = ((term * x2) / 64'd156) >> 30;
            sum  = sum + $signed(term);
            term = ((term * x2) / 64'd210) >> 30;
            sum  = sum - $signed(term);
            if (sum < 0) begin
                sum = '0;
            end
            v = (64'(sum) * 64'd16384 + 64'd536870912) >> 30;
            if (v > 64'd16384) begin
                v = 64'd16384;
            end
            tab[k] = cvg_pkg::SINE_W'(v);
        end
        return tab;
    endfunction

    localparam t_rom SINE_ROM = f_build_rom();

    logic [cvg_pkg::SINE_W-1:0] r_data_a;
    logic [cvg_pkg::SINE_W-1:0] r_data_b;

    // Registered reads, held while the pipeline stalls
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= SINE_ROM[i_addr_a];
            r_data_b <= SINE_ROM[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

`default_nettype wire

>>> hw/rtl/cvg_back.sv
// Back end: turns vertex commands into positions and normals through a
// five-stage pipeline ending in the output register. Depends on cvg_pkg, cvg_sine_rom.
`default_nettype none

module cvg_back #(
    parameter int unsigned SINE_ENTRIES = 1024
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cmd_valid,
    output logic                                      o_cmd_ready,
    input  cvg_pkg::t_vtx_cmd                         i_cmd,
    input  wire logic [cvg_pkg::RADIUS_W-1:0]         i_radius,
    input  wire logic signed [cvg_pkg::POS_W-1:0]     i_base_x,
    input  wire logic signed [cvg_pkg::POS_W-1:0]     i_base_y,
    input  wire logic signed [cvg_pkg::POS_W-1:0]     i_base_z,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [cvg_pkg::POS_W-1:0]          o_pos_x,
    output logic signed [cvg_pkg::POS_W-1:0]          o_pos_y,
    output logic signed [cvg_pkg::POS_W-1:0]          o_pos_z,
    output logic signed [cvg_pkg::NORM_W-1:0]         o_normal_x,
    output logic signed [cvg_pkg::NORM_W-1:0]         o_normal_y,
    output logic [cvg_pkg::SLOT_W-1:0]                o_vertex_slot,
    output logic                                      o_last
);

    localparam int unsigned ADDR_W  = $clog2(SINE_ENTRIES + 1);
    localparam int unsigned IDX_W   = 16 + ADDR_W;
    localparam int unsigned SW      = cvg_pkg::SINE_W;
    localparam int unsigned PROD_W  = cvg_pkg::RADIUS_W + SW;
    localparam int unsigned MAG_W   = PROD_W - 14;
    localparam int unsigned TERM_W  = MAG_W + 1;
    localparam int unsigned SUM_W   = 35;
    localparam int unsigned HW      = cvg_pkg::HEIGHT_W;
    localparam int unsigned PW      = cvg_pkg::POS_W;
    localparam int unsigned NW      = cvg_pkg::NORM_W;
    localparam logic signed [SUM_W-1:0] POS_MAX = 35'sd8388607;
    localparam logic signed [SUM_W-1:0] POS_MIN = -35'sd8388608;

    // Quarter-wave table index for an angle, rounded to nearest
    function automatic logic [ADDR_W-1:0] f_rom_addr(input logic [cvg_pkg::ANGLE_W-1:0] a);
        logic [14:0]      rem;
        logic [14:0]      phase;
        logic [IDX_W-1:0] scaled;
        rem    = {1'b0, a[13:0]};
        phase  = a[14] ? (15'(cvg_pkg::QUARTER_TURN) - rem) : rem;
        scaled = IDX_W'(phase) * IDX_W'(SINE_ENTRIES) + IDX_W'(8192);
        return scaled[14 +: ADDR_W];
    endfunction

    // Clamp a wide sum to the signed Q12.12 range
    function automatic logic signed [PW-1:0] f_sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [PW-1:0] res;
        if (v > POS_MAX) begin
            res = PW'(POS_MAX);
        end else if (v < POS_MIN) begin
            res = PW'(POS_MIN);
        end else begin
            res = v[PW-1:0];
        end
        return res;
    endfunction

    logic                          en;
    logic [cvg_pkg::ANGLE_W-1:0]   cos_angle;
    logic [SW-1:0]                 rom_c;
    logic [SW-1:0]                 rom_s;

    // Stage 1: table addresses
    logic                          r_s1_valid;
    logic [ADDR_W-1:0]             r_s1_addr_c;
    logic [ADDR_W-1:0]             r_s1_addr_s;
    logic                          r_s1_neg_c;
    logic                          r_s1_neg_s;
    logic [HW-1:0]                 r_s1_h;
    logic [cvg_pkg::SLOT_W-1:0]    r_s1_slot;
    logic                          r_s1_last;

    // Stage 2: table data (inside the ROM)
    logic                          r_s2_valid;
    logic                          r_s2_neg_c;
    logic                          r_s2_neg_s;
    logic [HW-1:0]                 r_s2_h;
    logic [cvg_pkg::SLOT_W-1:0]    r_s2_slot;
    logic                          r_s2_last;

    // Stage 3: radius products, normals, z position
    logic                          r_s3_valid;
    logic [PROD_W-1:0]             r_s3_prod_x;
    logic [PROD_W-1:0]             r_s3_prod_y;
    logic                          r_s3_neg_c;
    logic                          r_s3_neg_s;
    logic signed [NW-1:0]          r_s3_nx;
    logic signed [NW-1:0]          r_s3_ny;
    logic signed [PW-1:0]          r_s3_z;
    logic [cvg_pkg::SLOT_W-1:0]    r_s3_slot;
    logic                          r_s3_last;

    // Stage 4: rounded signed offsets
    logic                          r_s4_valid;
    logic signed [TERM_W-1:0]      r_s4_term_x;
    logic signed [TERM_W-1:0]      r_s4_term_y;
    logic signed [NW-1:0]          r_s4_nx;
    logic signed [NW-1:0]          r_s4_ny;
    logic signed [PW-1:0]          r_s4_z;
    logic [cvg_pkg::SLOT_W-1:0]    r_s4_slot;
    logic                          r_s4_last;

    // Output register
    logic                          r_out_valid;
    logic signed [PW-1:0]          r_pos_x;
    logic signed [PW-1:0]          r_pos_y;
    logic signed [PW-1:0]          r_pos_z;
    logic signed [NW-1:0]          r_nx;
    logic signed [NW-1:0]          r_ny;
    logic [cvg_pkg::SLOT_W-1:0]    r_slot;
    logic                          r_last;

    logic signed [SUM_W-1:0]       sum_x;
    logic signed [SUM_W-1:0]       sum_y;
    logic signed [SUM_W-1:0]       sum_z;
    logic [PROD_W-1:0]             rnd_x;
    logic [PROD_W-1:0]             rnd_y;
    logic [MAG_W-1:0]              mag_x;
    logic [MAG_W-1:0]              mag_y;

    // Whole pipeline advances when the output register can take a result
    assign en          = !r_out_valid || i_out_ready;
    assign o_cmd_ready = en;
    assign cos_angle   = i_cmd.angle + cvg_pkg::QUARTER_TURN;

    cvg_sine_rom #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_rom (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_addr_a (r_s1_addr_c),
        .i_addr_b (r_s1_addr_s),
        .o_data_a (rom_c),
        .o_data_b (rom_s)
    );

    // Datapath arithmetic between stages
    always_comb begin
        sum_z = SUM_W'(i_base_z) + SUM_W'(r_s2_h);
        rnd_x = r_s3_prod_x + PROD_W'(8192);
        rnd_y = r_s3_prod_y + PROD_W'(8192);
        mag_x = rnd_x[PROD_W-1:14];
        mag_y = rnd_y[PROD_W-1:14];
        sum_x = SUM_W'(i_base_x) + SUM_W'(r_s4_term_x);
        sum_y = SUM_W'(i_base_y) + SUM_W'(r_s4_term_y);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_cmd_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid;
        end
    end

    // Payload pipeline
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_addr_c <= f_rom_addr(cos_angle);
            r_s1_addr_s <= f_rom_addr(i_cmd.angle);
            r_s1_neg_c  <= cos_angle[cvg_pkg::ANGLE_W-1];
            r_s1_neg_s  <= i_cmd.angle[cvg_pkg::ANGLE_W-1];
            r_s1_h      <= i_cmd.height;
            r_s1_slot   <= i_cmd.slot;
            r_s1_last   <= i_cmd.last;

            r_s2_neg_c  <= r_s1_neg_c;
            r_s2_neg_s  <= r_s1_neg_s;
            r_s2_h      <= r_s1_h;
            r_s2_slot   <= r_s1_slot;
            r_s2_last   <= r_s1_last;

            r_s3_prod_x <= PROD_W'(i_radius) * PROD_W'(rom_c);
            r_s3_prod_y <= PROD_W'(i_radius) * PROD_W'(rom_s);
            r_s3_neg_c  <= r_s2_neg_c;
            r_s3_neg_s  <= r_s2_neg_s;
            r_s3_nx     <= r_s2_neg_c ? -NW'(rom_c) : NW'(rom_c);
            r_s3_ny     <= r_s2_neg_s ? -NW'(rom_s) : NW'(rom_s);
            r_s3_z      <= f_sat_pos(sum_z);
            r_s3_slot   <= r_s2_slot;
            r_s3_last   <= r_s2_last;

            r_s4_term_x <= r_s3_neg_c ? -TERM_W'(mag_x) : TERM_W'(mag_x);
            r_s4_term_y <= r_s3_neg_s ? -TERM_W'(mag_y) : TERM_W'(mag_y);
            r_s4_nx     <= r_s3_nx;
            r_s4_ny     <= r_s3_ny;
            r_s4_z      <= r_s3_z;
            r_s4_slot   <= r_s3_slot;
            r_s4_last   <= r_s3_last;

            r_pos_x     <= f_sat_pos(sum_x);
            r_pos_y     <= f_sat_pos(sum_y);
            r_pos_z     <= r_s4_z;
            r_nx        <= r_s4_nx;
            r_ny        <= r_s4_ny;
            r_slot      <= r_s4_slot;
            r_last      <= r_s4_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pos_x       = r_pos_x;
    assign o_pos_y       = r_pos_y;
    assign o_pos_z       = r_pos_z;
    assign o_normal_x    = r_nx;
    assign o_normal_y    = r_ny;
    assign o_vertex_slot = r_slot;
    assign o_last        = r_last;

endmodule

`default_nettype wire
